[rtl/hcbd_pkg.sv]
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types and constants of the chunked body decoder: decode phases,
// character codes, register map and the packing of the result tdata word.
// ----------------------------------------------------------------------------
package hcbd_pkg;

	// decode phase of the current chunk
	typedef enum logic [2:0] {
		PH_LEAD      = 3'd0,
		PH_LEAD_CR   = 3'd1,
		PH_DIGITS    = 3'd2,
		PH_DIGITS_CR = 3'd3,
		PH_DATA      = 3'd4,
		PH_TRAIL     = 3'd5,
		PH_TRAIL_CR  = 3'd6,
		PH_FINISHED  = 3'd7
	} phase_t;

	// character codes
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_VT  = 8'h0B;
	localparam logic [7:0] CH_FF  = 8'h0C;

	// buffer size limits
	localparam int unsigned MAX_BUFFER   = 65536;
	localparam int unsigned ADDR_SPACE   = 65536;
	localparam int unsigned CAP_MAX_INT  = (MAX_BUFFER < ADDR_SPACE) ? MAX_BUFFER : ADDR_SPACE;
	localparam logic [16:0] CAP_MAX      = 17'(CAP_MAX_INT);
	localparam logic [16:0] CAP_RESET    = 17'd4096;

	// register map, register index taken from paddr[2]
	localparam logic        REG_CAPACITY = 1'b0;

	// result tdata layout
	localparam int unsigned OUT_WE_BIT   = 0;
	localparam int unsigned OUT_ADDR_LSB = 1;
	localparam int unsigned OUT_DATA_LSB = 17;
	localparam int unsigned OUT_LEN_LSB  = 25;
	localparam int unsigned OUT_SAW_BIT  = 41;
	localparam int unsigned OUT_USED_W   = 42;
	localparam int unsigned OUT_TDATA_W  = 48;

endpackage

[rtl/http_chunked_body_decoder.sv]
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Decodes an HTTP chunked body one raw byte per transfer into buffer writes
// and reports the committed body length on the final byte.
// ----------------------------------------------------------------------------
// Usage:
// - s_* stream: one raw body byte per transfer in s_tdata[7:0], s_tlast marks
//   the final byte of the body.
// - m_* stream: exactly one result transfer per input transfer, in order.
//   It carries the buffer write (enable, address, data), the committed
//   length and the last-chunk flag; m_tlast echoes the input s_tlast.
// - APB port: register 0 (paddr 0) is the buffer capacity, terminator slot
//   included; write it only while no transfer is in flight.
// Each byte passes an input register, then one pass of decode logic into
// the result register. Throughput is one byte per clock while m_tready
// does not stall the result; the per-byte state update (size line parser,
// data counters) completes in that single decode pass.
// Reset clears all decode state and loads capacity 4096. After the result
// of a byte with s_tlast the decode state returns to reset, capacity kept.
// When m_tready is low the result register holds; the input register still
// takes one more byte, and s_tready drops only when both are full.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder
	import hcbd_pkg::*;
#(
	parameter int unsigned SIZE_LINE_CHARS = 31
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // last_byte
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] write_enable, [16:1] write_address, [24:17] write_data,
	// [40:25] body_length, [41] saw_last_chunk, [47:42] zero
	output logic [47:0] m_tdata,
	output logic        m_tlast,   // body_done
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int unsigned CNT_W = $clog2(SIZE_LINE_CHARS + 1);

	typedef struct packed {
		phase_t          ph;
		logic [30:0]     acc;
		logic            stop;
		logic [CNT_W-1:0] cnt;
	} line_t;

	function automatic logic is_space(logic [7:0] c);
		return (c == CH_SP) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) ||
			(c == CH_FF) || (c == CH_CR);
	endfunction

	// one character of the size line, within the character budget
	function automatic line_t line_char(line_t s, logic [7:0] c);
		line_t      r;
		logic       hex;
		logic [3:0] d;
		r   = s;
		hex = 1'b1;
		d   = 4'd0;
		if (c >= "0" && c <= "9") begin
			d = 4'(c - "0");
		end else if (c >= "a" && c <= "f") begin
			d = 4'(c - "a" + 8'd10);
		end else if (c >= "A" && c <= "F") begin
			d = 4'(c - "A" + 8'd10);
		end else begin
			hex = 1'b0;
		end
		if (s.cnt < CNT_W'(SIZE_LINE_CHARS)) begin
			r.cnt = s.cnt + 1'b1;
			if (!(s.ph == PH_LEAD && is_space(c))) begin
				r.ph = PH_DIGITS;
				if (!s.stop) begin
					if (!hex) begin
						r.stop = 1'b1;
					end else if (s.acc[30:27] != 4'd0) begin
						r.acc = '1;
					end else begin
						r.acc = {s.acc[26:0], d};
					end
				end
			end
		end
		return r;
	endfunction

	// a byte while on the size line
	function automatic line_t size_byte(line_t s, logic [7:0] c);
		line_t r;
		r = s;
		if (c == CH_CR) begin
			r.ph = (s.ph == PH_LEAD) ? PH_LEAD_CR : PH_DIGITS_CR;
		end else begin
			r = line_char(s, c);
		end
		return r;
	endfunction

	// configuration register
	logic [16:0] capacity_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
	assign prdata = (paddr[2] == REG_CAPACITY) ? {15'd0, capacity_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_wr) begin
			capacity_q <= pwdata[16:0];
		end
	end

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       out_ready;
	logic       adv;

	logic                   out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;
	logic                   out_last_q;

	assign out_ready = !out_valid_q || m_tready;
	assign adv       = valid_s1 && out_ready;
	assign s_tready  = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// decode state
	phase_t           phase_q;
	logic [30:0]      acc_q;
	logic             stop_q;
	logic [CNT_W-1:0] cnt_q;
	logic [30:0]      remain_q;
	logic [15:0]      commit_q;
	logic [15:0]      ptr_q;

	line_t       ln_n;
	logic [30:0] remain_n;
	logic [15:0] commit_n;
	logic [15:0] ptr_n;
	logic        we;
	logic [15:0] limit;

	logic [OUT_TDATA_W-1:0] out_word;

	// write limit from capacity, clamped
	always_comb begin
		logic [16:0] cap_eff;
		cap_eff = capacity_q;
		if (cap_eff == 17'd0) begin
			cap_eff = 17'd1;
		end
		if (cap_eff > CAP_MAX) begin
			cap_eff = CAP_MAX;
		end
		limit = 16'(cap_eff - 17'd1);
	end

	// next state for the byte in the input register
	always_comb begin
		line_t cur;
		line_t fresh;
		line_t tmp;
		cur      = '{ph: phase_q, acc: acc_q, stop: stop_q, cnt: cnt_q};
		fresh    = '{ph: PH_LEAD, acc: '0, stop: 1'b0, cnt: '0};
		tmp      = fresh;
		ln_n     = cur;
		remain_n = remain_q;
		commit_n = commit_q;
		ptr_n    = ptr_q;
		we       = 1'b0;
		unique case (phase_q)
			PH_LEAD, PH_DIGITS: begin
				ln_n = size_byte(cur, byte_s1);
			end
			PH_LEAD_CR, PH_DIGITS_CR: begin
				if (byte_s1 == CH_LF) begin
					// end of size line
					ln_n = fresh;
					if (acc_q == 31'd0) begin
						ln_n.ph = PH_FINISHED;
					end else begin
						remain_n = acc_q;
						ptr_n    = commit_q;
						ln_n.ph  = PH_DATA;
					end
				end else begin
					// lone CR is an ordinary line character
					tmp    = cur;
					tmp.ph = (phase_q == PH_LEAD_CR) ? PH_LEAD : PH_DIGITS;
					tmp    = line_char(tmp, CH_CR);
					ln_n   = size_byte(tmp, byte_s1);
				end
			end
			PH_DATA: begin
				we       = (ptr_q < limit);
				ptr_n    = ptr_q + 16'(we);
				remain_n = remain_q - 31'(remain_q != 31'd0);
				if (remain_n == 31'd0 || ptr_n >= limit) begin
					commit_n = ptr_n;
				end
				if (remain_n == 31'd0) begin
					ln_n.ph = PH_TRAIL;
				end
			end
			PH_TRAIL: begin
				if (byte_s1 == CH_CR) begin
					ln_n.ph = PH_TRAIL_CR;
				end else begin
					ln_n = size_byte(fresh, byte_s1);
				end
			end
			PH_TRAIL_CR: begin
				ln_n = fresh;
				if (byte_s1 != CH_LF) begin
					tmp  = line_char(fresh, CH_CR);
					ln_n = size_byte(tmp, byte_s1);
				end
			end
			default: begin
			end
		endcase
	end

	// state registers, cleared after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LEAD;
			acc_q    <= '0;
			stop_q   <= 1'b0;
			cnt_q    <= '0;
			remain_q <= '0;
			commit_q <= '0;
			ptr_q    <= '0;
		end else if (adv) begin
			if (last_s1) begin
				phase_q  <= PH_LEAD;
				acc_q    <= '0;
				stop_q   <= 1'b0;
				cnt_q    <= '0;
				remain_q <= '0;
				commit_q <= '0;
				ptr_q    <= '0;
			end else begin
				phase_q  <= ln_n.ph;
				acc_q    <= ln_n.acc;
				stop_q   <= ln_n.stop;
				cnt_q    <= ln_n.cnt;
				remain_q <= remain_n;
				commit_q <= commit_n;
				ptr_q    <= ptr_n;
			end
		end
	end

	// result word packing
	always_comb begin
		out_word                       = '0;
		out_word[OUT_WE_BIT]           = we;
		out_word[OUT_ADDR_LSB +: 16]   = we ? ptr_q : 16'd0;
		out_word[OUT_DATA_LSB +: 8]    = we ? byte_s1 : 8'd0;
		out_word[OUT_LEN_LSB +: 16]    = last_s1 ? commit_n : 16'd0;
		out_word[OUT_SAW_BIT]          = (ln_n.ph == PH_FINISHED);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= out_word;
			out_last_q <= last_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

[rtl/hcbd_checker.sv]
// ----------------------------------------------------------------------------
// hcbd_checker
// Port-level checks of the chunked body decoder result stream.
// ----------------------------------------------------------------------------
module hcbd_checker
	import hcbd_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic        m_tlast
);

	// stalled result holds its contents
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// no write means zero address and data
	a_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[OUT_WE_BIT] |->
			m_tdata[OUT_ADDR_LSB +: 16] == 16'd0 && m_tdata[OUT_DATA_LSB +: 8] == 8'd0)
		else $error("write fields set without write enable");

	// length only reported with the final byte
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[OUT_LEN_LSB +: 16] == 16'd0)
		else $error("body length outside the final transfer");

	// writes stay below the terminator slot of the largest buffer
	a_addr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[OUT_WE_BIT] |-> m_tdata[OUT_ADDR_LSB +: 16] != 16'hFFFF)
		else $error("write into terminator slot");

	// padding bits stay zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_TDATA_W-1:OUT_USED_W] == '0)
		else $error("nonzero tdata padding");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
